// ----- src/dha_pkg.sv -----
// shared types, constants and helpers for the dust history averager
package dha_pkg;

    // field widths
    localparam int DATA_W    = 10;
    localparam int OPC_W     = 2;
    localparam int MIN_W     = 6;
    localparam int IDX_W     = 5;
    localparam int CLS_W     = 3;
    localparam int CFG_IDX_W = 2;

    // default geometry
    localparam int SLOTS_PER_HOUR_DEF = 12;
    localparam int HISTORY_HOURS_DEF  = 24;

    // spacing of ring samples in minutes
    localparam int FIVE_MINUTES = 5;

    // opcodes
    localparam logic [OPC_W-1:0] OP_MINUTE = 2'd0;
    localparam logic [OPC_W-1:0] OP_HOUR   = 2'd1;
    localparam logic [OPC_W-1:0] OP_QUERY  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERY_GOOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODERATE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD       = 2'd3;

    // limit reset values
    localparam logic [DATA_W-1:0] LIMIT_VERY_GOOD_RST = 10'd15;
    localparam logic [DATA_W-1:0] LIMIT_GOOD_RST      = 10'd30;
    localparam logic [DATA_W-1:0] LIMIT_MODERATE_RST  = 10'd55;
    localparam logic [DATA_W-1:0] LIMIT_BAD_RST       = 10'd110;

    // air quality classes
    localparam logic [CLS_W-1:0] CLS_VERY_GOOD = 3'd0;
    localparam logic [CLS_W-1:0] CLS_GOOD      = 3'd1;
    localparam logic [CLS_W-1:0] CLS_MODERATE  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_BAD       = 3'd3;
    localparam logic [CLS_W-1:0] CLS_VERY_BAD  = 3'd4;

    // input transaction
    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [MIN_W-1:0]  minute;
        logic [DATA_W-1:0] dust_value;
        logic [IDX_W-1:0]  hour_index;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [DATA_W-1:0] hour_average;
        logic [CLS_W-1:0]  air_class;
    } t_out_item;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SUM,
        S_SUM_TAIL,
        S_DIV,
        S_HIST_WR,
        S_RD,
        S_DONE
    } t_state;

    // minute is a multiple of five, checked against the table of multiples
    function automatic logic is_five_minute(input logic [MIN_W-1:0] minute);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k * FIVE_MINUTES < (1 << MIN_W); k++) begin
            if (minute == MIN_W'(k * FIVE_MINUTES)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ----- src/dha_slot_ring.sv -----
// ring of five-minute dust samples with write pointer and per-slot valid bits
module dha_slot_ring #(
    parameter int SLOTS_PER_HOUR = dha_pkg::SLOTS_PER_HOUR_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic [dha_pkg::DATA_W-1:0]           i_wr_data,
    input  logic [$clog2(SLOTS_PER_HOUR)-1:0]    i_rd_addr,
    output logic [dha_pkg::DATA_W-1:0]           o_rd_data
);

    localparam int AW = $clog2(SLOTS_PER_HOUR);

    logic [dha_pkg::DATA_W-1:0] r_mem [SLOTS_PER_HOUR];
    logic [SLOTS_PER_HOUR-1:0]  r_vld;
    logic [SLOTS_PER_HOUR-1:0]  n_vld;
    logic [AW-1:0]              r_ptr;
    logic [AW-1:0]              n_ptr;
    logic [dha_pkg::DATA_W-1:0] r_rd_data;
    logic                       r_rd_vld;

    // pointer advance with wrap after the last slot
    always_comb begin
        n_ptr = r_ptr;
        n_vld = r_vld;
        if (i_wr_en) begin
            n_vld[r_ptr] = 1'b1;
            n_ptr = (r_ptr == AW'(SLOTS_PER_HOUR - 1)) ? '0 : r_ptr + 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_vld <= '0;
        end else begin
            r_ptr <= n_ptr;
            r_vld <= n_vld;
        end
    end

    // sample memory write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_ptr] <= i_wr_data;
        end
    end

    // registered read, never-written slots read as zero
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_vld  <= r_vld[i_rd_addr];
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- src/dha_hist_ring.sv -----
// hourly history kept as a ring with a moving head, newest entry at index 0
module dha_hist_ring #(
    parameter int HISTORY_HOURS = dha_pkg::HISTORY_HOURS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [dha_pkg::DATA_W-1:0]  i_push_data,
    input  logic [dha_pkg::IDX_W-1:0]   i_rd_index,
    output logic [dha_pkg::DATA_W-1:0]  o_rd_data
);

    localparam int AW = $clog2(HISTORY_HOURS);
    localparam int CW = dha_pkg::IDX_W + 2;

    logic [dha_pkg::DATA_W-1:0] r_mem [HISTORY_HOURS];
    logic [HISTORY_HOURS-1:0]   r_vld;
    logic [AW-1:0]              r_head;
    logic [AW-1:0]              n_head;
    logic [AW:0]                rd_sum;
    logic [AW-1:0]              rd_addr;
    logic                       rd_in_range;
    logic [dha_pkg::DATA_W-1:0] r_rd_data;
    logic                       r_rd_ok;

    // head moves down by one on every push, wrapping below zero
    assign n_head = (r_head == '0) ? AW'(HISTORY_HOURS - 1) : r_head - 1'b1;

    // logical index to physical address
    assign rd_in_range = CW'(i_rd_index) < CW'(HISTORY_HOURS);
    assign rd_sum      = (AW + 1)'(AW'(i_rd_index)) + (AW + 1)'(r_head);
    assign rd_addr     = (rd_sum >= (AW + 1)'(HISTORY_HOURS))
                       ? AW'(rd_sum - (AW + 1)'(HISTORY_HOURS))
                       : AW'(rd_sum);

    // head pointer and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_vld  <= '0;
        end else if (i_push) begin
            r_head         <= n_head;
            r_vld[n_head]  <= 1'b1;
        end
    end

    // history memory write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[n_head] <= i_push_data;
        end
    end

    // registered read, out of range or never-written entries read as zero
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        r_rd_ok   <= rd_in_range && r_vld[rd_addr];
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

// ----- src/dha_classify.sv -----
// limit registers and first-match air quality classification
module dha_classify (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [dha_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dha_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic [dha_pkg::DATA_W-1:0]     i_value,
    output logic [dha_pkg::CLS_W-1:0]      o_class
);

    logic [dha_pkg::DATA_W-1:0] r_lim_very_good;
    logic [dha_pkg::DATA_W-1:0] r_lim_good;
    logic [dha_pkg::DATA_W-1:0] r_lim_moderate;
    logic [dha_pkg::DATA_W-1:0] r_lim_bad;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_very_good <= dha_pkg::LIMIT_VERY_GOOD_RST;
            r_lim_good      <= dha_pkg::LIMIT_GOOD_RST;
            r_lim_moderate  <= dha_pkg::LIMIT_MODERATE_RST;
            r_lim_bad       <= dha_pkg::LIMIT_BAD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dha_pkg::CFG_VERY_GOOD: r_lim_very_good <= i_cfg_data;
                dha_pkg::CFG_GOOD:      r_lim_good      <= i_cfg_data;
                dha_pkg::CFG_MODERATE:  r_lim_moderate  <= i_cfg_data;
                dha_pkg::CFG_BAD:       r_lim_bad       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // compare chain in register order
    always_comb begin
        if (i_value < r_lim_very_good) begin
            o_class = dha_pkg::CLS_VERY_GOOD;
        end else if (i_value < r_lim_good) begin
            o_class = dha_pkg::CLS_GOOD;
        end else if (i_value < r_lim_moderate) begin
            o_class = dha_pkg::CLS_MODERATE;
        end else if (i_value < r_lim_bad) begin
            o_class = dha_pkg::CLS_BAD;
        end else begin
            o_class = dha_pkg::CLS_VERY_BAD;
        end
    end

endmodule

// ----- src/dust_history_averager.sv -----
// top level: sequencer with one shared adder for the slot sum and a reciprocal multiply
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_ready | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/ i_out_ready| o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// minute tick and query: decode, read and done states in turn, the result is registered on leaving done.
// hour tick: decode, sum, sum tail, divide, history write, read and done states in turn;
// the shared adder walks the slot ring one slot a cycle, then one reciprocal multiply
// divides the sum by the slot count.
// one transaction in flight; o_in_ready is high only while idle.
// a finished result waits in the output register, the next item is taken meanwhile.
// synchronous active-low reset clears pointers, valid bits and limits; no sweep.
module dust_history_averager #(
    parameter int SLOTS_PER_HOUR = dha_pkg::SLOTS_PER_HOUR_DEF,
    parameter int HISTORY_HOURS  = dha_pkg::HISTORY_HOURS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dha_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dha_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dha_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dha_pkg::DATA_W-1:0]     i_cfg_data
);

    localparam int SLOT_AW   = $clog2(SLOTS_PER_HOUR);
    localparam int SUM_W     = dha_pkg::DATA_W + $clog2(SLOTS_PER_HOUR);
    localparam int CNT_W     = SLOT_AW;
    // reciprocal of the slot count, exact for every sum the ring can hold
    localparam int DIV_SHIFT = SUM_W + $clog2(SLOTS_PER_HOUR);
    localparam int RCP_W     = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] DIV_RCP =
        RCP_W'(((1 << DIV_SHIFT) + SLOTS_PER_HOUR - 1) / SLOTS_PER_HOUR);

    dha_pkg::t_state    r_state, n_state;
    dha_pkg::t_in_item  r_item, n_item;
    logic [SUM_W-1:0]   r_acc, n_acc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    dha_pkg::t_out_item r_out_data, n_out_data;

    logic                       slot_wr;
    logic [dha_pkg::DATA_W-1:0] slot_rd_data;
    logic                       hist_push;
    logic [dha_pkg::DATA_W-1:0] hist_rd_data;
    logic [dha_pkg::CLS_W-1:0]  rd_class;

    logic [SUM_W-1:0]  alu_a;
    logic [SUM_W-1:0]  alu_b;
    logic [SUM_W-1:0]  alu_sum;
    logic [PROD_W-1:0] div_prod;

    // five-minute sample ring
    dha_slot_ring #(
        .SLOTS_PER_HOUR(SLOTS_PER_HOUR)
    ) u_slot_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (slot_wr),
        .i_wr_data (r_item.dust_value),
        .i_rd_addr (r_cnt),
        .o_rd_data (slot_rd_data)
    );

    // hourly history
    dha_hist_ring #(
        .HISTORY_HOURS(HISTORY_HOURS)
    ) u_hist_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (hist_push),
        .i_push_data (r_acc[dha_pkg::DATA_W-1:0]),
        .i_rd_index  (r_item.hour_index),
        .o_rd_data   (hist_rd_data)
    );

    // limits and classification
    dha_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_value     (hist_rd_data),
        .o_class     (rd_class)
    );

    // shared adder, the sum of all slots never overflows SUM_W
    assign alu_sum = alu_a + alu_b;

    // divide by the slot count as a multiply by its scaled reciprocal
    assign div_prod = PROD_W'(r_acc) * PROD_W'(DIV_RCP);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        slot_wr     = 1'b0;
        hist_push   = 1'b0;
        alu_a       = r_acc;
        alu_b       = SUM_W'(slot_rd_data);

        // result taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            dha_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = dha_pkg::S_DECODE;
                end
            end
            dha_pkg::S_DECODE: begin
                if (r_item.opcode == dha_pkg::OP_MINUTE) begin
                    slot_wr = dha_pkg::is_five_minute(r_item.minute);
                    n_state = dha_pkg::S_RD;
                end else if (r_item.opcode == dha_pkg::OP_HOUR) begin
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = dha_pkg::S_SUM;
                end else begin
                    n_state = dha_pkg::S_RD;
                end
            end
            dha_pkg::S_SUM: begin
                // read slot r_cnt, add the slot read in the previous cycle
                if (r_cnt != '0) begin
                    n_acc = alu_sum;
                end
                if (r_cnt == CNT_W'(SLOTS_PER_HOUR - 1)) begin
                    n_state = dha_pkg::S_SUM_TAIL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            dha_pkg::S_SUM_TAIL: begin
                n_acc   = alu_sum;
                n_cnt   = '0;
                n_state = dha_pkg::S_DIV;
            end
            dha_pkg::S_DIV: begin
                // truncated average, always fits the data width
                n_acc   = SUM_W'(div_prod[DIV_SHIFT +: dha_pkg::DATA_W]);
                n_state = dha_pkg::S_HIST_WR;
            end
            dha_pkg::S_HIST_WR: begin
                hist_push = 1'b1;
                n_state   = dha_pkg::S_RD;
            end
            dha_pkg::S_RD: begin
                n_state = dha_pkg::S_DONE;
            end
            dha_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid             = 1'b1;
                    n_out_data.hour_average = hist_rd_data;
                    n_out_data.air_class    = rd_class;
                    n_state                 = dha_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dha_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dha_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_acc      <= n_acc;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

    assign o_in_ready  = (r_state == dha_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- src/dha_checker.sv -----
// port-level checks for the dust history averager, bound to the top level
module dha_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input dha_pkg::t_out_item i_out_data
);

    // class code never beyond very bad
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.air_class <= dha_pkg::CLS_VERY_BAD))
        else $error("air class out of range");

    // one transaction in flight: input closes after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready after accept");

    // reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("not idle after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind dust_history_averager dha_checker u_dha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

// ----- dv/tb.sv -----
// self-checking testbench for the dust history averager: random traffic against a predictor
module tb;
    import dha_pkg::*;

    localparam int SLOTS         = SLOTS_PER_HOUR_DEF;
    localparam int HOURS         = HISTORY_HOURS_DEF;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 250;
    localparam int HOLD_AT       = 150;
    localparam int MAX_REPORTS   = 200;

    // opcode that the block treats as a plain query
    localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [DATA_W-1:0]     i_cfg_data  = '0;

    dust_history_averager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the block state
    logic [DATA_W-1:0] ring_slot [SLOTS];
    int unsigned       ring_ptr;
    logic [DATA_W-1:0] hour_hist [HOURS];
    logic [DATA_W-1:0] limit_reg [4];

    t_in_item  pending_items [$];
    t_out_item expected_hours [$];

    bit calm_tail = 1'b0;
    int n_errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_samples = 0;
    int n_hour_ticks = 0;
    int n_cfg_writes = 0;
    int class_seen [5] = '{default: 0};

    // first-match threshold chain in register order
    function automatic logic [CLS_W-1:0] classify_dust(input logic [DATA_W-1:0] v);
        if (v < limit_reg[CFG_VERY_GOOD]) return CLS_VERY_GOOD;
        if (v < limit_reg[CFG_GOOD]) return CLS_GOOD;
        if (v < limit_reg[CFG_MODERATE]) return CLS_MODERATE;
        if (v < limit_reg[CFG_BAD]) return CLS_BAD;
        return CLS_VERY_BAD;
    endfunction

    // apply one transaction to the shadow state and return the reported entry
    function automatic t_out_item predict_hour_report(input t_in_item it);
        t_out_item   res;
        int unsigned sum;
        logic [DATA_W-1:0] val;
        sum = 0;
        val = '0;
        case (it.opcode)
            OP_MINUTE: begin
                if ((it.minute % FIVE_MINUTES) == 0) begin
                    ring_slot[ring_ptr] = it.dust_value;
                    ring_ptr = (ring_ptr + 1) % SLOTS;
                    n_samples++;
                end
            end
            OP_HOUR: begin
                for (int h = HOURS - 1; h > 0; h--) hour_hist[h] = hour_hist[h - 1];
                for (int s = 0; s < SLOTS; s++) sum += ring_slot[s];
                hour_hist[0] = DATA_W'(sum / SLOTS);
                n_hour_ticks++;
            end
            default: ;
        endcase
        if (it.hour_index < HOURS) val = hour_hist[it.hour_index];
        res.hour_average = val;
        res.air_class = classify_dust(val);
        return res;
    endfunction

    function automatic t_in_item make_item(input logic [OPC_W-1:0] op, input int minute,
                                           input int dust, input int idx);
        t_in_item it;
        it.opcode = op;
        it.minute = MIN_W'(minute);
        it.dust_value = DATA_W'(dust);
        it.hour_index = IDX_W'(idx);
        return it;
    endfunction

    // mostly recent hours, some older ones, a few past the end of the history
    function automatic int pick_index();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return $urandom_range(0, 3);
        if (r < 19) return $urandom_range(4, HOURS - 1);
        return $urandom_range(HOURS, 31);
    endfunction

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= DATA_W'(val);
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        limit_reg[idx] = DATA_W'(val);
        n_cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_sorted_limits(input int cap);
        int v [4];
        int t;
        foreach (v[k]) v[k] = $urandom_range(0, cap);
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3 - a; b++) begin
                if (v[b] > v[b + 1]) begin
                    t = v[b];
                    v[b] = v[b + 1];
                    v[b + 1] = t;
                end
            end
        end
        write_limit(CFG_VERY_GOOD, v[0]);
        write_limit(CFG_GOOD, v[1]);
        write_limit(CFG_MODERATE, v[2]);
        write_limit(CFG_BAD, v[3]);
    endtask

    // hours of five-minute samples closed by an hour tick, plus partial hours and noise
    task automatic add_random_items(input int count);
        int added;
        int r;
        int n_ticks;
        int dust_cap;
        int dust_fixed;
        int start;
        bit steady;
        added = 0;
        while (added < count) begin
            r = $urandom_range(0, 9);
            if (r < 8) begin
                n_ticks = (r < 6) ? SLOTS : $urandom_range(1, SLOTS + 3);
                case ($urandom_range(0, 2))
                    0: dust_cap = 63;
                    1: dust_cap = 150;
                    default: dust_cap = 1023;
                endcase
                steady = ($urandom_range(0, 3) == 0);
                dust_fixed = $urandom_range(0, dust_cap);
                start = $urandom_range(0, 11);
                for (int k = 0; k < n_ticks; k++) begin
                    pending_items.push_back(make_item(OP_MINUTE, (5 * (k + start)) % 60,
                        steady ? dust_fixed : $urandom_range(0, dust_cap), pick_index()));
                    added++;
                    if ($urandom_range(0, 5) == 0) begin
                        pending_items.push_back(make_item(OP_QUERY, $urandom_range(0, 63),
                            $urandom_range(0, 1023), pick_index()));
                        added++;
                    end
                end
                pending_items.push_back(make_item(OP_HOUR, $urandom_range(0, 63),
                    $urandom_range(0, 1023), pick_index()));
                added++;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    pending_items.push_back(make_item(OPC_W'($urandom_range(0, 3)),
                        $urandom_range(0, 63), $urandom_range(0, 1023),
                        $urandom_range(0, 31)));
                    added++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_hours.size() != 0);
    endtask

    // driver: offers pending items, with random gaps between transactions
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_hours.push_back(predict_hour_report(i_in_data));
                n_items++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 17);
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transaction and drives the receiver stalls
    int stall_left = 0;
    t_out_item exp_item;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_hours.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, got hour_average %0d air_class %0d",
                             $time, o_out_data.hour_average, o_out_data.air_class);
            end else begin
                exp_item = expected_hours.pop_front();
                if (o_out_data.air_class <= CLS_VERY_BAD) class_seen[o_out_data.air_class]++;
                if (o_out_data.hour_average !== exp_item.hour_average) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: hour_average mismatch, expected %0d got %0d",
                                 $time, exp_item.hour_average, o_out_data.hour_average);
                end
                if (o_out_data.air_class !== exp_item.air_class) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: air_class mismatch, expected %0d got %0d",
                                 $time, exp_item.air_class, o_out_data.air_class);
                end
            end
            // one long hold-off so the block backs up into its input
            if (n_results == HOLD_AT) stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("** dust_history_averager: FAILED **");
                $finish;
            end
        end
    end

    // sequence of phases
    initial begin
        foreach (ring_slot[k]) ring_slot[k] = '0;
        foreach (hour_hist[k]) hour_hist[k] = '0;
        ring_ptr = 0;
        limit_reg[CFG_VERY_GOOD] = LIMIT_VERY_GOOD_RST;
        limit_reg[CFG_GOOD]      = LIMIT_GOOD_RST;
        limit_reg[CFG_MODERATE]  = LIMIT_MODERATE_RST;
        limit_reg[CFG_BAD]       = LIMIT_BAD_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items with the reset limits
        @(negedge i_clk);
        pending_items.push_back(make_item(OP_QUERY, 0, 0, 0));
        pending_items.push_back(make_item(OP_QUERY, 63, 1023, 31));
        // spare opcode stores nothing
        pending_items.push_back(make_item(OP_SPARE, 0, 1023, 0));
        pending_items.push_back(make_item(OP_HOUR, 0, 1023, 0));
        for (int k = 0; k < SLOTS; k++)
            pending_items.push_back(make_item(OP_MINUTE, 5 * k, 1023, k));
        // minute 60 still counts and wraps the ring
        pending_items.push_back(make_item(OP_MINUTE, 60, 1023, 0));
        pending_items.push_back(make_item(OP_MINUTE, 63, 0, 0));
        pending_items.push_back(make_item(OP_MINUTE, 7, 0, 1));
        pending_items.push_back(make_item(OP_HOUR, 0, 0, 0));
        pending_items.push_back(make_item(OP_HOUR, 0, 0, 1));
        pending_items.push_back(make_item(OP_MINUTE, 0, 0, 2));
        pending_items.push_back(make_item(OP_QUERY, 0, 0, HOURS - 1));
        pending_items.push_back(make_item(OP_QUERY, 0, 0, HOURS));
        wait_drained();

        // ordered limits across the full range
        set_sorted_limits(1023);
        @(negedge i_clk);
        add_random_items(300);
        wait_drained();

        // all limits at zero
        write_limit(CFG_VERY_GOOD, 0);
        write_limit(CFG_GOOD, 0);
        write_limit(CFG_MODERATE, 0);
        write_limit(CFG_BAD, 0);
        @(negedge i_clk);
        add_random_items(150);
        wait_drained();

        // all limits at the top
        write_limit(CFG_VERY_GOOD, 1023);
        write_limit(CFG_GOOD, 1023);
        write_limit(CFG_MODERATE, 1023);
        write_limit(CFG_BAD, 1023);
        @(negedge i_clk);
        add_random_items(150);
        wait_drained();

        // limits out of order
        write_limit(CFG_VERY_GOOD, $urandom_range(400, 1023));
        write_limit(CFG_GOOD, $urandom_range(0, 120));
        write_limit(CFG_MODERATE, $urandom_range(150, 600));
        write_limit(CFG_BAD, $urandom_range(0, 80));
        @(negedge i_clk);
        add_random_items(200);
        wait_drained();

        // tight limits in the low range
        set_sorted_limits(200);
        @(negedge i_clk);
        add_random_items(300);
        wait_drained();

        // last stretch at full rate
        set_sorted_limits(1023);
        @(negedge i_clk);
        calm_tail = 1'b1;
        add_random_items(300);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d items: %0d five-minute samples, %0d hour ticks, %0d limit writes",
                 n_items, n_samples, n_hour_ticks, n_cfg_writes);
        $display("air classes seen 0..4: %0d %0d %0d %0d %0d", class_seen[0], class_seen[1],
                 class_seen[2], class_seen[3], class_seen[4]);
        if (n_errors == 0 && expected_hours.size() == 0) begin
            $display("** dust_history_averager: PASSED **");
        end else begin
            $display("** dust_history_averager: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/dha_pkg.sv
src/dha_slot_ring.sv
src/dha_hist_ring.sv
src/dha_classify.sv
src/dust_history_averager.sv
src/dha_checker.sv
dv/tb.sv
